FILE: sv/tst_pkg.sv
// Shared types and constants for the touch swipe tracker.
// No dependencies; used by every module of the block and by its checker.
package tst_pkg;

   localparam int MIN_BITS   = 12;
   localparam int STAMP_BITS = 32;
   localparam logic [MIN_BITS-1:0] MIN_RESET = 12'd28;

   typedef enum logic [1:0] {
      KIND_DOWN  = 2'd0,
      KIND_MOVE  = 2'd1,
      KIND_UP    = 2'd2,
      KIND_SWIPE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      DIR_NONE  = 3'd0,
      DIR_LEFT  = 3'd1,
      DIR_RIGHT = 3'd2,
      DIR_UP    = 3'd3,
      DIR_DOWN  = 3'd4
   } dir_type;

   // control part of one result
   typedef struct packed {
      kind_type kind;
      dir_type  dir;
      logic     last;
   } rsp_ctl_type;

endpackage

FILE: sv/tst_event_unit.sv
// Gesture state and event decode for one touch sample.
// Depends on tst_pkg.
module tst_event_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic                          smp_pressed,
   input  logic [COORD_BITS-1:0]         smp_x,
   input  logic [COORD_BITS-1:0]         smp_y,
   input  logic [tst_pkg::MIN_BITS-1:0]  min_dist,
   output logic [1:0]                    res_cnt,
   output tst_pkg::rsp_ctl_type          res_ctl0,
   output tst_pkg::rsp_ctl_type          res_ctl1,
   output logic [COORD_BITS-1:0]         res_px,
   output logic [COORD_BITS-1:0]         res_py
);

   localparam int CMP_BITS = (COORD_BITS > tst_pkg::MIN_BITS) ? COORD_BITS : tst_pkg::MIN_BITS;

   logic                  tracking_ff, tracking_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in;
   logic [COORD_BITS-1:0] start_y_ff, start_y_in;
   logic [COORD_BITS-1:0] last_x_ff, last_x_in;
   logic [COORD_BITS-1:0] last_y_ff, last_y_in;

   logic [COORD_BITS:0]   dx, dy, adx_w, ady_w;
   logic                  dx_neg, dy_neg;
   logic [CMP_BITS-1:0]   adx_c, ady_c, min_c;
   logic                  swipe_hit;
   tst_pkg::dir_type      swipe_dir;

   // displacement from start to last point
   assign dx     = {1'b0, last_x_ff} - {1'b0, start_x_ff};
   assign dy     = {1'b0, last_y_ff} - {1'b0, start_y_ff};
   assign dx_neg = dx[COORD_BITS];
   assign dy_neg = dy[COORD_BITS];
   assign adx_w  = dx_neg ? (~dx + 1'b1) : dx;
   assign ady_w  = dy_neg ? (~dy + 1'b1) : dy;
   assign adx_c  = CMP_BITS'(adx_w[COORD_BITS-1:0]);
   assign ady_c  = CMP_BITS'(ady_w[COORD_BITS-1:0]);
   assign min_c  = CMP_BITS'(min_dist);

   assign swipe_hit = (adx_c >= min_c) || (ady_c >= min_c);

   // horizontal wins ties
   always_comb begin
      if (adx_c >= ady_c) begin
         swipe_dir = dx_neg ? tst_pkg::DIR_LEFT : tst_pkg::DIR_RIGHT;
      end else begin
         swipe_dir = dy_neg ? tst_pkg::DIR_UP : tst_pkg::DIR_DOWN;
      end
   end

   always_comb begin
      res_cnt       = 2'd0;
      res_ctl0.kind = tst_pkg::KIND_DOWN;
      res_ctl0.dir  = tst_pkg::DIR_NONE;
      res_ctl0.last = 1'b1;
      res_ctl1.kind = tst_pkg::KIND_SWIPE;
      res_ctl1.dir  = swipe_dir;
      res_ctl1.last = 1'b1;
      res_px        = smp_x;
      res_py        = smp_y;
      tracking_in   = tracking_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      if (smp_pressed) begin
         if (!tracking_ff) begin
            res_cnt     = 2'd1;
            tracking_in = 1'b1;
            start_x_in  = smp_x;
            start_y_in  = smp_y;
         end else if ((smp_x != last_x_ff) || (smp_y != last_y_ff)) begin
            res_cnt       = 2'd1;
            res_ctl0.kind = tst_pkg::KIND_MOVE;
         end
         last_x_in = smp_x;
         last_y_in = smp_y;
      end else if (tracking_ff) begin
         res_ctl0.kind = tst_pkg::KIND_UP;
         res_px        = last_x_ff;
         res_py        = last_y_ff;
         tracking_in   = 1'b0;
         if (swipe_hit) begin
            res_cnt       = 2'd2;
            res_ctl0.last = 1'b0;
         end else begin
            res_cnt = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff <= 1'b0;
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         last_x_ff   <= '0;
         last_y_ff   <= '0;
      end else if (go) begin
         tracking_ff <= tracking_in;
         start_x_ff  <= start_x_in;
         start_y_ff  <= start_y_in;
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
      end
   end

endmodule

FILE: sv/tst_rsp_buf.sv
// Result buffer: holds the one or two results of a sample and presents them in turn.
// Depends on tst_pkg.
module tst_rsp_buf #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [1:0]                      load_cnt,
   input  tst_pkg::rsp_ctl_type            load_ctl0,
   input  tst_pkg::rsp_ctl_type            load_ctl1,
   input  logic [COORD_BITS-1:0]           load_px,
   input  logic [COORD_BITS-1:0]           load_py,
   input  logic [tst_pkg::STAMP_BITS-1:0]  load_stamp,
   output logic                            can_load,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_event_kind,
   output logic [2:0]                      rsp_direction,
   output logic [COORD_BITS-1:0]           rsp_point_x,
   output logic [COORD_BITS-1:0]           rsp_point_y,
   output logic [tst_pkg::STAMP_BITS-1:0]  rsp_stamp_ms,
   output logic                            rsp_last_of_run
);

   logic [1:0]                     cnt_ff;
   tst_pkg::rsp_ctl_type           ctl0_ff, ctl1_ff;
   logic [COORD_BITS-1:0]          px_ff, py_ff;
   logic [tst_pkg::STAMP_BITS-1:0] stamp_ff;
   logic                           take;

   assign take     = rsp_valid && !rsp_stall;
   assign can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && take);

   // both results of a sample share point and stamp
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= load_cnt;
      end else if (take) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl0_ff  <= load_ctl0;
         ctl1_ff  <= load_ctl1;
         px_ff    <= load_px;
         py_ff    <= load_py;
         stamp_ff <= load_stamp;
      end else if (take) begin
         ctl0_ff <= ctl1_ff;
      end
   end

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_event_kind  = ctl0_ff.kind;
   assign rsp_direction   = ctl0_ff.dir;
   assign rsp_last_of_run = ctl0_ff.last;
   assign rsp_point_x     = px_ff;
   assign rsp_point_y     = py_ff;
   assign rsp_stamp_ms    = stamp_ff;

endmodule

FILE: sv/touch_swipe_tracker.sv
// Touch swipe tracker, top level. A transferred sample is held in the sample register and
// is decoded into the result register once the result buffer can take its results.
// Throughput: one sample per cycle while the receiver does not stall; a release that gives
// an up and a swipe stalls the next sample while the result buffer hands out the up. Reset is
// synchronous, active high: not tracking, start and last points zero,
// swipe_min_distance 28, no result pending. Depends on tst_pkg, tst_event_unit, tst_rsp_buf.
module touch_swipe_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_pressed,
   input  logic [COORD_BITS-1:0]           req_touch_x,
   input  logic [COORD_BITS-1:0]           req_touch_y,
   input  logic [tst_pkg::STAMP_BITS-1:0]  req_time_ms,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_event_kind,
   output logic [2:0]                      rsp_direction,
   output logic [COORD_BITS-1:0]           rsp_point_x,
   output logic [COORD_BITS-1:0]           rsp_point_y,
   output logic [tst_pkg::STAMP_BITS-1:0]  rsp_stamp_ms,
   output logic                            rsp_last_of_run,
   // swipe_min_distance write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tst_pkg::MIN_BITS-1:0]    csr_wdata
);

   // sample register
   logic                           smp_vld_ff;
   logic                           smp_pressed_ff;
   logic [COORD_BITS-1:0]          smp_x_ff, smp_y_ff;
   logic [tst_pkg::STAMP_BITS-1:0] smp_t_ff;

   logic [tst_pkg::MIN_BITS-1:0]   min_dist_ff;

   logic                           go;
   logic                           can_load;
   logic [1:0]                     res_cnt;
   tst_pkg::rsp_ctl_type           res_ctl0, res_ctl1;
   logic [COORD_BITS-1:0]          res_px, res_py;

   // The held sample is decoded as soon as the result buffer can take its results.
   // A sample that gives no result still advances the state and frees the register.
   assign go        = smp_vld_ff && can_load;
   assign req_stall = smp_vld_ff && !go;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= tst_pkg::MIN_RESET;
      end else if (csr_valid) begin
         min_dist_ff <= csr_wdata;
      end
   end

   // Hold the sample until decoded; load a new one on each transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         smp_vld_ff <= 1'b1;
      end else if (go) begin
         smp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         smp_pressed_ff <= req_pressed;
         smp_x_ff       <= req_touch_x;
         smp_y_ff       <= req_touch_y;
         smp_t_ff       <= req_time_ms;
      end
   end

   // Tracking state, down/move/up decode and the swipe test.
   tst_event_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_event (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .smp_pressed (smp_pressed_ff),
      .smp_x       (smp_x_ff),
      .smp_y       (smp_y_ff),
      .min_dist    (min_dist_ff),
      .res_cnt     (res_cnt),
      .res_ctl0    (res_ctl0),
      .res_ctl1    (res_ctl1),
      .res_px      (res_px),
      .res_py      (res_py)
   );

   // Result register: up to two results per sample, handed out one per transfer.
   tst_rsp_buf #(
      .COORD_BITS (COORD_BITS)
   ) u_rsp (
      .clock           (clock),
      .reset           (reset),
      .load            (go),
      .load_cnt        (res_cnt),
      .load_ctl0       (res_ctl0),
      .load_ctl1       (res_ctl1),
      .load_px         (res_px),
      .load_py         (res_py),
      .load_stamp      (smp_t_ff),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_direction   (rsp_direction),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_stamp_ms    (rsp_stamp_ms),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: sv/tst_checker.sv
// Port-level checks for the touch swipe tracker, bound to the top level.
// Depends on tst_pkg and touch_swipe_tracker.
module tst_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [1:0]                      rsp_event_kind,
   input logic [2:0]                      rsp_direction,
   input logic [COORD_BITS-1:0]           rsp_point_x,
   input logic [COORD_BITS-1:0]           rsp_point_y,
   input logic [tst_pkg::STAMP_BITS-1:0]  rsp_stamp_ms,
   input logic                            rsp_last_of_run
);

   logic is_swipe, is_up;

   assign is_swipe = (rsp_event_kind == tst_pkg::KIND_SWIPE);
   assign is_up    = (rsp_event_kind == tst_pkg::KIND_UP);

   // a stalled result stays up
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_event_kind) && $stable(rsp_direction)
         && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_stamp_ms)
         && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // swipe closes its run and carries a direction; other events carry none
   a_dir_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (is_swipe && rsp_last_of_run && (rsp_direction != tst_pkg::DIR_NONE))
         || (!is_swipe && (rsp_direction == tst_pkg::DIR_NONE)))
      else $error("direction does not match event kind");

   // an up that is not last is followed at once by its swipe, same point and stamp
   a_up_then_swipe : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && is_up && !rsp_last_of_run |=> rsp_valid && is_swipe
         && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_stamp_ms))
      else $error("up without following swipe");

endmodule

bind touch_swipe_tracker tst_checker #(.COORD_BITS(COORD_BITS)) u_tst_checker (.*);

FILE: test/touch_event_checker.sv
`timescale 1ns / 100ps
// Event scoreboard for touch_swipe_tracker: follows the press state from sample transfers,
// predicts down, move, up and swipe events and checks result transfers in order.
// Depends on tst_pkg.
module touch_event_checker #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_pressed,
   input  logic [COORD_BITS-1:0]           req_touch_x,
   input  logic [COORD_BITS-1:0]           req_touch_y,
   input  logic [tst_pkg::STAMP_BITS-1:0]  req_time_ms,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [1:0]                      rsp_event_kind,
   input  logic [2:0]                      rsp_direction,
   input  logic [COORD_BITS-1:0]           rsp_point_x,
   input  logic [COORD_BITS-1:0]           rsp_point_y,
   input  logic [tst_pkg::STAMP_BITS-1:0]  rsp_stamp_ms,
   input  logic                            rsp_last_of_run,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [tst_pkg::MIN_BITS-1:0]    csr_wdata,
   input  logic                            run_end,
   output int unsigned                     mismatches,
   output int unsigned                     outstanding
);

   typedef struct packed {
      tst_pkg::kind_type                kind;
      tst_pkg::dir_type                 dir;
      logic [COORD_BITS-1:0]            x;
      logic [COORD_BITS-1:0]            y;
      logic [tst_pkg::STAMP_BITS-1:0]   stamp;
      logic                             last;
   } touch_event_type;

   touch_event_type                awaited_events[$];
   logic                           pressing;
   logic [COORD_BITS-1:0]          start_x, start_y, last_x, last_y;
   logic [tst_pkg::MIN_BITS-1:0]   swipe_min;
   bit                             end_checked;

   task automatic report_mismatch(input string what);
      if (mismatches < 100)
         $display("%0t ns  touch events: %s", $time, what);
      mismatches++;
   endtask

   task automatic queue_event(input tst_pkg::kind_type kind, input tst_pkg::dir_type dir,
                              input logic [COORD_BITS-1:0] x, y,
                              input logic [tst_pkg::STAMP_BITS-1:0] stamp,
                              input logic last);
      touch_event_type ev;
      ev.kind  = kind;
      ev.dir   = dir;
      ev.x     = x;
      ev.y     = y;
      ev.stamp = stamp;
      ev.last  = last;
      awaited_events.push_back(ev);
   endtask

   // advance the press state by one sample and queue the events it causes
   task automatic track_sample(input logic pressed, input logic [COORD_BITS-1:0] x, y,
                               input logic [tst_pkg::STAMP_BITS-1:0] stamp);
      int               dx, dy, adx, ady;
      logic             swipe;
      tst_pkg::dir_type dir;
      if (pressed) begin
         if (!pressing) begin
            start_x  = x;
            start_y  = y;
            pressing = 1'b1;
            queue_event(tst_pkg::KIND_DOWN, tst_pkg::DIR_NONE, x, y, stamp, 1'b1);
         end else if (x != last_x || y != last_y) begin
            queue_event(tst_pkg::KIND_MOVE, tst_pkg::DIR_NONE, x, y, stamp, 1'b1);
         end
         last_x = x;
         last_y = y;
      end else if (pressing) begin
         dx    = int'(last_x) - int'(start_x);
         dy    = int'(last_y) - int'(start_y);
         adx   = (dx < 0) ? -dx : dx;
         ady   = (dy < 0) ? -dy : dy;
         swipe = (adx >= int'(swipe_min)) || (ady >= int'(swipe_min));
         queue_event(tst_pkg::KIND_UP, tst_pkg::DIR_NONE, last_x, last_y, stamp, !swipe);
         if (swipe) begin
            // ties go to the horizontal axis
            if (adx >= ady)
               dir = (dx < 0) ? tst_pkg::DIR_LEFT : tst_pkg::DIR_RIGHT;
            else
               dir = (dy < 0) ? tst_pkg::DIR_UP : tst_pkg::DIR_DOWN;
            queue_event(tst_pkg::KIND_SWIPE, dir, last_x, last_y, stamp, 1'b1);
         end
         pressing = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      touch_event_type want;
      if (reset) begin
         pressing  = 1'b0;
         start_x   = '0;
         start_y   = '0;
         last_x    = '0;
         last_y    = '0;
         swipe_min = tst_pkg::MIN_RESET;
         awaited_events.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_events.size() == 0) begin
               report_mismatch("result transfer with no event awaited");
            end else begin
               want = awaited_events.pop_front();
               if (rsp_event_kind !== want.kind)
                  report_mismatch($sformatf("event_kind %0d, want %0d",
                                            rsp_event_kind, want.kind));
               if (rsp_direction !== want.dir)
                  report_mismatch($sformatf("direction %0d, want %0d",
                                            rsp_direction, want.dir));
               if (rsp_point_x !== want.x)
                  report_mismatch($sformatf("point_x %0d, want %0d", rsp_point_x, want.x));
               if (rsp_point_y !== want.y)
                  report_mismatch($sformatf("point_y %0d, want %0d", rsp_point_y, want.y));
               if (rsp_stamp_ms !== want.stamp)
                  report_mismatch($sformatf("stamp_ms %h, want %h", rsp_stamp_ms, want.stamp));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %0b, want %0b",
                                            rsp_last_of_run, want.last));
            end
         end
         if (csr_valid && csr_ready)
            swipe_min = csr_wdata;
         if (req_valid && !req_stall)
            track_sample(req_pressed, req_touch_x, req_touch_y, req_time_ms);
         if (run_end && !end_checked) begin
            end_checked = 1'b1;
            if (awaited_events.size() != 0)
               report_mismatch($sformatf("%0d events never arrived", awaited_events.size()));
         end
      end
      outstanding = awaited_events.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for touch_swipe_tracker: drives touch samples and swipe_min_distance
// writes, throttles both channels and gives the verdict.
// Depends on tst_pkg, touch_swipe_tracker and touch_event_checker.
module tb_top;

   localparam int CB        = 12;
   localparam int MB        = tst_pkg::MIN_BITS;
   localparam int COORD_MAX = (1 << CB) - 1;
   localparam int MIN_MAX   = (1 << MB) - 1;

   logic                            clock           = 1'b0;
   logic                            reset           = 1'b1;
   logic                            req_valid       = 1'b0;
   logic                            req_stall;
   logic                            req_pressed     = 1'b0;
   logic [CB-1:0]                   req_touch_x     = '0;
   logic [CB-1:0]                   req_touch_y     = '0;
   logic [tst_pkg::STAMP_BITS-1:0]  req_time_ms     = '0;
   logic                            rsp_valid;
   logic                            rsp_stall       = 1'b0;
   logic [1:0]                      rsp_event_kind;
   logic [2:0]                      rsp_direction;
   logic [CB-1:0]                   rsp_point_x;
   logic [CB-1:0]                   rsp_point_y;
   logic [tst_pkg::STAMP_BITS-1:0]  rsp_stamp_ms;
   logic                            rsp_last_of_run;
   logic                            csr_valid       = 1'b0;
   logic                            csr_ready;
   logic [MB-1:0]                   csr_wdata       = '0;
   logic                            run_end         = 1'b0;
   int unsigned                     mismatches;
   int unsigned                     outstanding;

   // throttle settings of the current phase, in percent
   int unsigned                     send_idle_pct   = 0;
   int unsigned                     recv_stall_pct  = 0;
   // local copy of the swipe threshold, used to aim gestures at its edge
   logic [MB-1:0]                   swipe_min_cfg   = tst_pkg::MIN_RESET;
   int unsigned                     samples_sent    = 0;
   logic [tst_pkg::STAMP_BITS-1:0]  stamp_now       = '0;

   always #10 clock = ~clock;

   touch_swipe_tracker #(.COORD_BITS(CB)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pressed     (req_pressed),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_direction   (rsp_direction),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_stamp_ms    (rsp_stamp_ms),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   touch_event_checker #(.COORD_BITS(CB)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pressed     (req_pressed),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_direction   (rsp_direction),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_stamp_ms    (rsp_stamp_ms),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .run_end         (run_end),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   // Receiver side: stall at random, freely from cycle to cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Present one sample and hold it until its transfer. The task returns on the falling
   // edge after the transfer with valid still high, so a back-to-back sample only swaps
   // the payload; an idle gap lowers valid first.
   task automatic send_sample(input logic pressed, input logic [CB-1:0] x, y,
                              input logic [tst_pkg::STAMP_BITS-1:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_pressed <= pressed;
      req_touch_x <= x;
      req_touch_y <= y;
      req_time_ms <= stamp;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      samples_sent++;
   endtask

   // Drop valid and wait for every awaited event, then let the pipeline settle:
   // a release while idle or a still press leaves work in flight with nothing awaited.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write swipe_min_distance; only called with the block drained.
   task automatic write_swipe_min(input logic [MB-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid     <= 1'b0;
      swipe_min_cfg  = value;
   endtask

   // Advance the sample clock, now and then jumping anywhere in the 32-bit range.
   function automatic logic [tst_pkg::STAMP_BITS-1:0] next_stamp();
      if ($urandom_range(15) == 0)
         stamp_now = $urandom;
      else
         stamp_now += $urandom_range(40, 1);
      return stamp_now;
   endfunction

   // Move a coordinate by delta, clamped to the screen.
   function automatic logic [CB-1:0] shift_coord(input logic [CB-1:0] base, input int delta);
      int v;
      v = int'(base) + delta;
      if (v < 0)
         v = 0;
      else if (v > COORD_MAX)
         v = COORD_MAX;
      return v[CB-1:0];
   endfunction

   // One well-formed gesture: press, a few moves of mixed kinds, release.
   task automatic play_gesture();
      logic [CB-1:0] sx, sy, px, py;
      int            reach;
      sx = CB'($urandom_range(COORD_MAX));
      sy = CB'($urandom_range(COORD_MAX));
      px = sx;
      py = sy;
      send_sample(1'b1, sx, sy, next_stamp());
      repeat ($urandom_range(6)) begin
         case ($urandom_range(3))
            0: ;  // hold still: no move event expected
            1: begin
               px = shift_coord(px, int'($urandom_range(16)) - 8);
               py = shift_coord(py, int'($urandom_range(16)) - 8);
            end
            2: begin
               // land one pixel short of, on, or past the swipe threshold
               reach = int'(swipe_min_cfg) + int'($urandom_range(2)) - 1;
               if ($urandom_range(1))
                  reach = -reach;
               case ($urandom_range(2))
                  0: begin
                     px = shift_coord(sx, reach);
                     py = sy;
                  end
                  1: begin
                     px = sx;
                     py = shift_coord(sy, reach);
                  end
                  default: begin
                     // diagonal, equal reach: exercise the horizontal tie rule
                     px = shift_coord(sx, reach);
                     py = shift_coord(sy, $urandom_range(1) ? reach : -reach);
                  end
               endcase
            end
            default: begin
               px = CB'($urandom_range(COORD_MAX));
               py = CB'($urandom_range(COORD_MAX));
            end
         endcase
         send_sample(1'b1, px, py, next_stamp());
      end
      send_sample(1'b0, CB'($urandom_range(COORD_MAX)), CB'($urandom_range(COORD_MAX)),
                  next_stamp());
   endtask

   initial begin
      int unsigned phase_stop;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed samples at the reset threshold of 28.
      send_sample(1'b0, CB'(COORD_MAX), CB'(COORD_MAX), 32'h0000_0000); // release while idle
      send_sample(1'b1, 0, 0, 32'h0000_0000);                 // down at the origin
      send_sample(1'b1, 0, 0, 32'h0000_0001);                 // same point: no event
      send_sample(1'b1, CB'(COORD_MAX), 0, 32'hFFFF_FFFF);    // move to the far corner
      send_sample(1'b1, CB'(COORD_MAX), CB'(COORD_MAX), 32'hFFFF_FFFE);
      send_sample(1'b0, 0, 0, 32'h8000_0000);                 // tie on both axes: right
      send_sample(1'b1, 100, 100, 32'd10);
      send_sample(1'b1, 60, 100, 32'd11);
      send_sample(1'b0, 0, 0, 32'd12);                        // swipe left
      send_sample(1'b1, 100, 100, 32'd20);
      send_sample(1'b1, 110, 50, 32'd21);
      send_sample(1'b0, 0, 0, 32'd22);                        // swipe up
      send_sample(1'b1, 100, 100, 32'd30);
      send_sample(1'b1, 100, 130, 32'd31);
      send_sample(1'b0, 0, 0, 32'd32);                        // swipe down
      send_sample(1'b1, 200, 200, 32'd40);
      send_sample(1'b1, 227, 200, 32'd41);
      send_sample(1'b0, 0, 0, 32'd42);                        // one pixel short: up only
      send_sample(1'b1, 200, 200, 32'd50);
      send_sample(1'b1, 200, 172, 32'd51);
      send_sample(1'b0, 0, 0, 32'd52);                        // exactly on threshold: swipe up

      // Zero threshold: a release without movement still swipes, to the right.
      hold_until_drained();
      write_swipe_min('0);
      send_sample(1'b1, 5, 5, 32'd60);
      send_sample(1'b0, 5, 5, 32'd61);

      // Largest threshold: only a full-width drag swipes.
      hold_until_drained();
      write_swipe_min(MB'(MIN_MAX));
      send_sample(1'b1, 0, 0, 32'd70);
      send_sample(1'b1, CB'(COORD_MAX), 10, 32'd71);
      send_sample(1'b0, 0, 0, 32'd72);
      send_sample(1'b1, CB'(COORD_MAX), 0, 32'd80);
      send_sample(1'b1, 0, 0, 32'd81);
      send_sample(1'b0, 0, 0, 32'd82);

      // Random phases, each with its own threshold and throttle mix.
      for (int phase = 0; phase < 4; phase++) begin
         hold_until_drained();
         case (phase)
            0: begin
               write_swipe_min(1);
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               write_swipe_min(MB'($urandom_range(MIN_MAX)));
               send_idle_pct  = 83;
               recv_stall_pct = 0;
            end
            2: begin
               write_swipe_min(tst_pkg::MIN_RESET);
               send_idle_pct  = 0;
               recv_stall_pct = 83;
            end
            default: begin
               write_swipe_min(MB'($urandom_range(64)));
               send_idle_pct  = 7;
               recv_stall_pct = 7;
            end
         endcase
         phase_stop = samples_sent + 160;
         while (samples_sent < phase_stop) begin
            if ($urandom_range(4) == 0) begin
               // noise: loose presses and releases, broken gestures included
               repeat ($urandom_range(3, 1))
                  send_sample(1'($urandom_range(1)), CB'($urandom_range(COORD_MAX)),
                              CB'($urandom_range(COORD_MAX)), next_stamp());
            end else begin
               play_gesture();
            end
            // now and then let the result side run dry mid-phase
            if ($urandom_range(63) == 0)
               hold_until_drained();
         end
      end

      hold_until_drained();
      run_end <= 1'b1;
      @(negedge clock);
      @(negedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
